FILE: sv/asd_pkg.sv
package asd_pkg;

    typedef enum logic [1:0] {
        PH_HDR_LO = 2'd0,
        PH_HDR_HI = 2'd1,
        PH_RAW    = 2'd2,
        PH_RUN    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MODE_RAW    = 2'b00,
        MODE_SINGLE = 2'b01,
        MODE_RUN    = 2'b10,
        MODE_BAD    = 2'b11
    } t_mode;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_RAW_SIZE   = 4'd1,
        ERR_SINGLE_HDR = 4'd2,
        ERR_SPAN       = 4'd3,
        ERR_PAD        = 4'd4,
        ERR_RUN_SIZE   = 4'd5,
        ERR_ZERO_RUN   = 4'd6,
        ERR_OVERFLOW   = 4'd7,
        ERR_SHORT      = 4'd8,
        ERR_MODE       = 4'd9
    } t_err;

    localparam logic [6:0] SPAN_MAX = 7'd64;

    typedef struct packed {
        logic [6:0]  run_value;
        logic [15:0] repeat_res;
        logic        frame_end;
        t_err        error_code;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

    function automatic t_res mk_res(logic [6:0] val, logic [15:0] rep, logic fin, t_err err);
        t_res r;
        r.run_value  = val;
        r.repeat_res = rep;
        r.frame_end  = fin;
        r.error_code = err;
        return r;
    endfunction

endpackage

FILE: sv/asd_front.sv
module asd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [15:0]      i_cfg_span_count,
    input  logic             i_valid,
    input  logic [7:0]       i_stream_byte,
    input  logic             i_space,
    output logic             o_ready,
    output asd_pkg::t_push   o_push
);

    function automatic logic [1:0] mod3_14(logic [13:0] x);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 7; i++) begin
            s = s + {3'b000, x[2*i +: 2]};
        end
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]} + {2'b00, s[4]};
        u = {1'b0, t[1:0]} + {2'b00, t[2]};
        if (u >= 3'd3) begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    asd_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_span_count;
    logic [7:0]      r_header_low, n_header_low;
    logic [13:0]     r_bytes_left, n_bytes_left;
    logic [13:0]     r_bit_buffer, n_bit_buffer;
    logic [3:0]      r_bits_held, n_bits_held;
    logic [15:0]     r_spans_done, n_spans_done;
    logic [1:0]      r_entry_idx, n_entry_idx;
    logic [15:0]     r_run_hold, n_run_hold;

    logic        accept;
    logic [7:0]  b;
    logic [13:0] bytes_dec;
    logic        last;
    logic [1:0]  hdr_mode;
    logic [13:0] hdr_pay;
    logic [18:0] sc7;
    logic [18:0] expect_bytes;
    logic [22:0] raw_buf;
    logic [4:0]  raw_held;
    logic [4:0]  held1;
    logic        take0;
    logic        take1;
    logic [6:0]  v0;
    logic [6:0]  v1;
    logic [22:0] buf_final;
    logic [4:0]  held_final;
    logic [16:0] run_sum;

    assign o_ready   = i_space;
    assign accept    = i_valid && i_space;
    assign b         = i_stream_byte;
    assign bytes_dec = r_bytes_left - 14'd1;
    assign last      = (bytes_dec == 14'd0);
    assign hdr_mode  = b[7:6];
    assign hdr_pay   = {b[5:0], r_header_low};
    assign sc7          = ({3'b000, r_span_count} << 3) - {3'b000, r_span_count};
    assign expect_bytes = (sc7 + 19'd7) >> 3;

    assign raw_buf  = {9'd0, r_bit_buffer} | ({15'd0, b} << r_bits_held);
    assign raw_held = {1'b0, r_bits_held} + 5'd8;
    assign held1    = raw_held - 5'd7;
    assign take0    = (raw_held >= 5'd7) && (r_spans_done < r_span_count);
    assign take1    = take0 && (held1 >= 5'd7)
                      && (({1'b0, r_spans_done} + 17'd1) < {1'b0, r_span_count});
    assign v0       = raw_buf[6:0];
    assign v1       = raw_buf[13:7];
    assign buf_final  = take1 ? (raw_buf >> 14) : (take0 ? (raw_buf >> 7) : raw_buf);
    assign held_final = take1 ? (raw_held - 5'd14) : (take0 ? held1 : raw_held);
    assign run_sum    = {1'b0, r_spans_done} + {1'b0, r_run_hold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= asd_pkg::PH_HDR_LO;
            r_span_count <= '0;
            r_header_low <= '0;
            r_bytes_left <= '0;
            r_bit_buffer <= '0;
            r_bits_held  <= '0;
            r_spans_done <= '0;
            r_entry_idx  <= '0;
            r_run_hold   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_header_low <= n_header_low;
            r_bytes_left <= n_bytes_left;
            r_bit_buffer <= n_bit_buffer;
            r_bits_held  <= n_bits_held;
            r_spans_done <= n_spans_done;
            r_entry_idx  <= n_entry_idx;
            r_run_hold   <= n_run_hold;
            if (i_cfg_valid) begin
                r_span_count <= i_cfg_span_count;
            end
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_header_low = r_header_low;
        n_bytes_left = r_bytes_left;
        n_bit_buffer = r_bit_buffer;
        n_bits_held  = r_bits_held;
        n_spans_done = r_spans_done;
        n_entry_idx  = r_entry_idx;
        n_run_hold   = r_run_hold;
        o_push       = '0;
        if (accept) begin
            unique case (r_phase)
                asd_pkg::PH_HDR_LO: begin
                    n_header_low = b;
                    n_phase      = asd_pkg::PH_HDR_HI;
                end
                asd_pkg::PH_HDR_HI: begin
                    n_phase      = asd_pkg::PH_HDR_LO;
                    n_bytes_left = '0;
                    n_bit_buffer = '0;
                    n_bits_held  = '0;
                    n_spans_done = '0;
                    n_entry_idx  = '0;
                    n_run_hold   = '0;
                    o_push.cnt   = 2'd1;
                    unique case (hdr_mode)
                        asd_pkg::MODE_RAW: begin
                            if ({5'd0, hdr_pay} != expect_bytes) begin
                                o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1,
                                                            asd_pkg::ERR_RAW_SIZE);
                            end else if (hdr_pay == 14'd0) begin
                                o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_NONE);
                            end else begin
                                o_push.cnt   = 2'd0;
                                n_bytes_left = hdr_pay;
                                n_phase      = asd_pkg::PH_RAW;
                            end
                        end
                        asd_pkg::MODE_SINGLE: begin
                            if (hdr_pay[13:7] != 7'd0) begin
                                o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1,
                                                            asd_pkg::ERR_SINGLE_HDR);
                            end else if (hdr_pay[6:0] > asd_pkg::SPAN_MAX) begin
                                o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_SPAN);
                            end else begin
                                o_push.r0 = asd_pkg::mk_res(hdr_pay[6:0], r_span_count, 1'b1,
                                                            asd_pkg::ERR_NONE);
                            end
                        end
                        asd_pkg::MODE_RUN: begin
                            if (hdr_pay == 14'd0 || mod3_14(hdr_pay) != 2'd0) begin
                                o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1,
                                                            asd_pkg::ERR_RUN_SIZE);
                            end else begin
                                o_push.cnt   = 2'd0;
                                n_bytes_left = hdr_pay;
                                n_phase      = asd_pkg::PH_RUN;
                            end
                        end
                        default: begin
                            o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_MODE);
                        end
                    endcase
                end
                asd_pkg::PH_RAW: begin
                    n_bytes_left = bytes_dec;
                    if ((take0 && v0 > asd_pkg::SPAN_MAX) || (take1 && v1 > asd_pkg::SPAN_MAX)) begin
                        o_push.cnt = 2'd1;
                        o_push.r0  = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_SPAN);
                        n_phase    = asd_pkg::PH_HDR_LO;
                    end else begin
                        n_spans_done = r_spans_done + (take1 ? 16'd2 : (take0 ? 16'd1 : 16'd0));
                        o_push.cnt   = take1 ? 2'd2 : (take0 ? 2'd1 : 2'd0);
                        if (last) begin
                            n_phase = asd_pkg::PH_HDR_LO;
                            if (buf_final != 23'd0) begin
                                o_push.cnt = 2'd1;
                                o_push.r0  = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_PAD);
                            end else begin
                                n_bit_buffer = '0;
                                n_bits_held  = '0;
                                if (!take0) begin
                                    o_push.cnt = 2'd1;
                                    o_push.r0  = asd_pkg::mk_res('0, '0, 1'b1,
                                                                 asd_pkg::ERR_NONE);
                                end else begin
                                    o_push.r0 = asd_pkg::mk_res(v0, 16'd1, !take1,
                                                                asd_pkg::ERR_NONE);
                                    o_push.r1 = asd_pkg::mk_res(v1, 16'd1, 1'b1,
                                                                asd_pkg::ERR_NONE);
                                end
                            end
                        end else begin
                            n_bit_buffer = buf_final[13:0];
                            n_bits_held  = held_final[3:0];
                            o_push.r0    = asd_pkg::mk_res(v0, 16'd1, 1'b0, asd_pkg::ERR_NONE);
                            o_push.r1    = asd_pkg::mk_res(v1, 16'd1, 1'b0, asd_pkg::ERR_NONE);
                        end
                    end
                end
                asd_pkg::PH_RUN: begin
                    n_bytes_left = bytes_dec;
                    priority if (r_entry_idx == 2'd0) begin
                        n_run_hold  = {8'd0, b};
                        n_entry_idx = 2'd1;
                    end else if (r_entry_idx == 2'd1) begin
                        n_run_hold  = {b, r_run_hold[7:0]};
                        n_entry_idx = 2'd2;
                    end else begin
                        n_entry_idx = 2'd0;
                        o_push.cnt  = 2'd1;
                        if (r_run_hold == 16'd0) begin
                            o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_ZERO_RUN);
                            n_phase   = asd_pkg::PH_HDR_LO;
                        end else if (b > {1'b0, asd_pkg::SPAN_MAX}) begin
                            o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_SPAN);
                            n_phase   = asd_pkg::PH_HDR_LO;
                        end else if (run_sum > {1'b0, r_span_count}) begin
                            o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1, asd_pkg::ERR_OVERFLOW);
                            n_phase   = asd_pkg::PH_HDR_LO;
                        end else begin
                            n_spans_done = run_sum[15:0];
                            if (last) begin
                                n_phase = asd_pkg::PH_HDR_LO;
                                if (run_sum[15:0] != r_span_count) begin
                                    o_push.r0 = asd_pkg::mk_res('0, '0, 1'b1,
                                                                asd_pkg::ERR_SHORT);
                                end else begin
                                    o_push.r0 = asd_pkg::mk_res(b[6:0], r_run_hold, 1'b1,
                                                                asd_pkg::ERR_NONE);
                                end
                            end else begin
                                o_push.r0 = asd_pkg::mk_res(b[6:0], r_run_hold, 1'b0,
                                                            asd_pkg::ERR_NONE);
                            end
                        end
                    end
                end
                default: begin
                    n_phase = asd_pkg::PH_HDR_LO;
                end
            endcase
        end
    end

endmodule

FILE: sv/asd_rq.sv
module asd_rq #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  asd_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_space,
    output logic             o_head_valid,
    output asd_pkg::t_res    o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    asd_pkg::t_res r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] wp1;
    logic [AW-1:0] wp2;

    assign wp1 = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
    assign wp2 = (wp1 == AW'(DEPTH - 1)) ? '0 : wp1 + AW'(1);

    assign o_space      = (r_cnt <= CW'(DEPTH - 2));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt + CW'(i_push.cnt) - CW'(i_pop);
        if (i_push.cnt == 2'd1) begin
            n_wp = wp1;
        end else if (i_push.cnt == 2'd2) begin
            n_wp = wp2;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: sv/asd_back.sv
module asd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  asd_pkg::t_res    i_head,
    input  logic             i_ready,
    output logic             o_pop,
    output logic             o_valid,
    output asd_pkg::t_res    o_res
);

    logic          r_valid, n_valid;
    asd_pkg::t_res r_res;

    assign o_pop   = i_head_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

endmodule

FILE: sv/adaptive_span_stream_decoder_unit.sv
// channel   direction  handshake                 word
// cfg       in         i_cfg_valid / o_cfg_ready i_cfg_span_count
// stream    in         i_valid / o_ready         i_stream_byte
// result    out        o_valid / i_ready         o_run_value, o_repeat_res,
//                                                o_frame_end, o_error_code
// One byte a cycle enters while o_ready is high; its results go through the result queue into the output register.
// A raw byte may give two results, which drain one a cycle through the result queue while i_ready is high.
// o_ready drops only while the queue has fewer than two free places.
// Synchronous active-low reset empties the queue and awaits a header.
module adaptive_span_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_span_count,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_stream_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_run_value,
    output logic [15:0] o_repeat_res,
    output logic        o_frame_end,
    output logic [3:0]  o_error_code
);

    asd_pkg::t_push push;
    asd_pkg::t_res  head;
    asd_pkg::t_res  res;
    logic           space;
    logic           head_valid;
    logic           pop;

    assign o_cfg_ready = 1'b1;

    asd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_span_count (i_cfg_span_count),
        .i_valid          (i_valid),
        .i_stream_byte    (i_stream_byte),
        .i_space          (space),
        .o_ready          (o_ready),
        .o_push           (push)
    );

    asd_rq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_rq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_space      (space),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    asd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_ready      (i_ready),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_res        (res)
    );

    assign o_run_value  = res.run_value;
    assign o_repeat_res = res.repeat_res;
    assign o_frame_end  = res.frame_end;
    assign o_error_code = res.error_code;

endmodule

FILE: sv/asd_checker.sv
module asd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [15:0] i_cfg_span_count,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_stream_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [6:0]  o_run_value,
    input logic [15:0] o_repeat_res,
    input logic        o_frame_end,
    input logic [3:0]  o_error_code
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != asd_pkg::ERR_NONE |->
            o_frame_end && o_run_value == 7'd0 && o_repeat_res == 16'd0)
        else $error("error word not terminal or not empty");

    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_end |->
            o_error_code == asd_pkg::ERR_NONE && o_repeat_res != 16'd0)
        else $error("non-final word without a run");

    a_span_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_run_value <= asd_pkg::SPAN_MAX)
        else $error("span value out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_run_value)
            && $stable(o_repeat_res) && $stable(o_frame_end) && $stable(o_error_code))
        else $error("stalled result word changed");

endmodule

bind adaptive_span_stream_decoder_unit asd_checker u_asd_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY     = 8;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic [15:0] i_cfg_span_count = 16'd0;
    logic        i_valid          = 1'b0;
    logic [7:0]  i_stream_byte    = 8'd0;
    logic        i_ready          = 1'b0;
    logic        o_cfg_ready;
    logic        o_ready;
    logic        o_valid;
    logic [6:0]  o_run_value;
    logic [15:0] o_repeat_res;
    logic        o_frame_end;
    logic [3:0]  o_error_code;

    adaptive_span_stream_decoder_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_span_count (i_cfg_span_count),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_stream_byte    (i_stream_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_run_value      (o_run_value),
        .o_repeat_res     (o_repeat_res),
        .o_frame_end      (o_frame_end),
        .o_error_code     (o_error_code)
    );

    always #2 i_clk = ~i_clk;

    int               fail_count         = 0;
    int               cycle_count        = 0;
    int               bytes_sent         = 0;
    int               sender_idle_pct    = 0;
    int               receiver_stall_pct = 0;
    int               holdoff_left       = 0;
    asd_pkg::t_res    expected_runs [$];
    asd_pkg::t_res    oldest_run;

    asd_pkg::t_phase  dec_phase;
    logic [7:0]       hdr_lo;
    logic [13:0]      left_bytes;
    logic [13:0]      bitbuf;
    logic [3:0]       nbits;
    logic [16:0]      spans_made;
    logic [1:0]       entry_pos;
    logic [15:0]      run_len;
    logic [15:0]      cfg_spans;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("tb: mismatch on %s: got %0d want %0d (cycle %0d)",
                 what, got, want, cycle_count);
        fail_count++;
    endtask

    task automatic push_run(input logic [6:0] v, input logic [15:0] rep, input logic fin,
                            input asd_pkg::t_err e);
        asd_pkg::t_res r;
        r.run_value  = v;
        r.repeat_res = rep;
        r.frame_end  = fin;
        r.error_code = e;
        expected_runs.push_back(r);
    endtask

    task automatic frame_error(input asd_pkg::t_err e);
        push_run(7'd0, 16'd0, 1'b1, e);
        dec_phase = asd_pkg::PH_HDR_LO;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [15:0] hdr;
        logic [13:0] pay;
        logic [31:0] want;
        logic [31:0] acc;
        logic [31:0] held;
        logic [6:0]  vals [2];
        int          n;
        bit          last;
        bit          failed;
        case (dec_phase)
            asd_pkg::PH_HDR_HI: begin
                hdr        = {b, hdr_lo};
                pay        = hdr[13:0];
                dec_phase  = asd_pkg::PH_HDR_LO;
                left_bytes = '0;
                bitbuf     = '0;
                nbits      = '0;
                spans_made = '0;
                entry_pos  = '0;
                run_len    = '0;
                case (asd_pkg::t_mode'(hdr[15:14]))
                    asd_pkg::MODE_RAW: begin
                        want = (7 * 32'(cfg_spans) + 7) / 8;
                        if (32'(pay) != want) begin
                            frame_error(asd_pkg::ERR_RAW_SIZE);
                        end else if (pay == 0) begin
                            push_run(7'd0, 16'd0, 1'b1, asd_pkg::ERR_NONE);
                        end else begin
                            left_bytes = pay;
                            dec_phase  = asd_pkg::PH_RAW;
                        end
                    end
                    asd_pkg::MODE_SINGLE: begin
                        if (pay[13:7] != 0) begin
                            frame_error(asd_pkg::ERR_SINGLE_HDR);
                        end else if (pay > 14'(asd_pkg::SPAN_MAX)) begin
                            frame_error(asd_pkg::ERR_SPAN);
                        end else begin
                            push_run(pay[6:0], cfg_spans, 1'b1, asd_pkg::ERR_NONE);
                        end
                    end
                    asd_pkg::MODE_RUN: begin
                        if (pay == 0 || (pay % 3) != 0) begin
                            frame_error(asd_pkg::ERR_RUN_SIZE);
                        end else begin
                            left_bytes = pay;
                            dec_phase  = asd_pkg::PH_RUN;
                        end
                    end
                    default: frame_error(asd_pkg::ERR_MODE);
                endcase
            end
            asd_pkg::PH_RAW: begin
                acc        = 32'(bitbuf) | (32'(b) << nbits);
                held       = 32'(nbits) + 8;
                n          = 0;
                failed     = 1'b0;
                left_bytes = left_bytes - 14'd1;
                last       = (left_bytes == 0);
                while (held >= 7 && spans_made < 17'(cfg_spans) && n < 2 && !failed) begin
                    if (acc[6:0] > asd_pkg::SPAN_MAX) begin
                        failed = 1'b1;
                    end else begin
                        vals[n]    = acc[6:0];
                        n++;
                        acc        = acc >> 7;
                        held       = held - 7;
                        spans_made = spans_made + 17'd1;
                    end
                end
                if (failed) begin
                    frame_error(asd_pkg::ERR_SPAN);
                end else if (last) begin
                    if (acc != 0) begin
                        frame_error(asd_pkg::ERR_PAD);
                    end else begin
                        dec_phase = asd_pkg::PH_HDR_LO;
                        bitbuf    = '0;
                        nbits     = '0;
                        if (n == 0) begin
                            push_run(7'd0, 16'd0, 1'b1, asd_pkg::ERR_NONE);
                        end
                        for (int k = 0; k < n; k++) begin
                            push_run(vals[k], 16'd1, (k == n - 1), asd_pkg::ERR_NONE);
                        end
                    end
                end else begin
                    bitbuf = acc[13:0];
                    nbits  = held[3:0];
                    for (int k = 0; k < n; k++) begin
                        push_run(vals[k], 16'd1, 1'b0, asd_pkg::ERR_NONE);
                    end
                end
            end
            asd_pkg::PH_RUN: begin
                left_bytes = left_bytes - 14'd1;
                if (entry_pos == 0) begin
                    run_len   = {8'd0, b};
                    entry_pos = 2'd1;
                end else if (entry_pos == 1) begin
                    run_len[15:8] = b;
                    entry_pos     = 2'd2;
                end else begin
                    entry_pos = 2'd0;
                    if (run_len == 0) begin
                        frame_error(asd_pkg::ERR_ZERO_RUN);
                    end else if (b > 8'(asd_pkg::SPAN_MAX)) begin
                        frame_error(asd_pkg::ERR_SPAN);
                    end else if (32'(spans_made) + 32'(run_len) > 32'(cfg_spans)) begin
                        frame_error(asd_pkg::ERR_OVERFLOW);
                    end else begin
                        spans_made = spans_made + 17'(run_len);
                        if (left_bytes == 0) begin
                            if (spans_made != 17'(cfg_spans)) begin
                                frame_error(asd_pkg::ERR_SHORT);
                            end else begin
                                push_run(b[6:0], run_len, 1'b1, asd_pkg::ERR_NONE);
                                dec_phase = asd_pkg::PH_HDR_LO;
                            end
                        end else begin
                            push_run(b[6:0], run_len, 1'b0, asd_pkg::ERR_NONE);
                        end
                    end
                end
            end
            default: begin
                hdr_lo    = b;
                dec_phase = asd_pkg::PH_HDR_HI;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input asd_pkg::t_mode m, input logic [13:0] pay);
        send_byte(pay[7:0]);
        send_byte({m, pay[13:8]});
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_span_count(input logic [15:0] v);
        i_cfg_valid      <= 1'b1;
        i_cfg_span_count <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_spans = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [6:0] pick_span();
        case ($urandom_range(7))
            0:       return 7'd0;
            1:       return asd_pkg::SPAN_MAX;
            default: return 7'($urandom_range(64));
        endcase
    endfunction

    function automatic logic [15:0] pick_span_count();
        case ($urandom_range(19))
            0, 1:    return 16'd0;
            2:       return 16'hFFFF;
            3, 4:    return 16'd1;
            default: return 16'($urandom_range(2, 30));
        endcase
    endfunction

    task automatic send_raw_frame(input bit corrupt);
        logic [511:0] bits;
        int unsigned  cnt;
        int unsigned  pay;
        int unsigned  flaw;
        int unsigned  pos;
        cnt  = cfg_spans;
        pay  = (7 * cnt + 7) / 8;
        flaw = corrupt ? $urandom_range(2) : 3;
        if (cnt > 64 || flaw == 0) begin
            send_header(asd_pkg::MODE_RAW, 14'(pay + $urandom_range(1, 3)));
            return;
        end
        bits = '0;
        for (int k = 0; k < cnt; k++) begin
            bits[7 * k +: 7] = pick_span();
        end
        if (flaw == 1 && cnt > 0) begin
            bits[7 * $urandom_range(cnt - 1) +: 7] = 7'($urandom_range(65, 127));
        end
        if (flaw == 2 && 8 * pay > 7 * cnt) begin
            pos       = $urandom_range(7 * cnt, 8 * pay - 1);
            bits[pos] = 1'b1;
        end
        send_header(asd_pkg::MODE_RAW, 14'(pay));
        for (int k = 0; k < pay; k++) begin
            send_byte(bits[8 * k +: 8]);
        end
    endtask

    task automatic send_single_frame(input bit corrupt);
        case (corrupt ? $urandom_range(1) : 2)
            0:       send_header(asd_pkg::MODE_SINGLE,
                                 {7'($urandom_range(1, 127)), 7'($urandom_range(127))});
            1:       send_header(asd_pkg::MODE_SINGLE, 14'($urandom_range(65, 127)));
            default: send_header(asd_pkg::MODE_SINGLE, {7'd0, pick_span()});
        endcase
    endtask

    task automatic send_run_frame(input bit corrupt);
        logic [15:0] runs [8];
        logic [7:0]  vals [8];
        int unsigned cnt;
        int unsigned k;
        int unsigned rem;
        int unsigned flaw;
        int unsigned j;
        cnt  = cfg_spans;
        flaw = corrupt ? $urandom_range(4) : 5;
        if (flaw == 0) begin
            if ($urandom_range(1) == 0) begin
                send_header(asd_pkg::MODE_RUN, 14'd0);
            end else begin
                send_header(asd_pkg::MODE_RUN,
                            14'(3 * $urandom_range(1, 5) + $urandom_range(1, 2)));
            end
            return;
        end
        k   = (cnt == 0) ? 1 : $urandom_range(1, (cnt < 6) ? cnt : 6);
        rem = cnt;
        for (int i = 0; i < k - 1; i++) begin
            runs[i] = 16'($urandom_range(1, rem - (k - 1 - i)));
            rem     = rem - runs[i];
        end
        runs[k - 1] = (cnt == 0) ? 16'd1 : 16'(rem);
        for (int i = 0; i < k; i++) begin
            vals[i] = {1'b0, pick_span()};
        end
        j = $urandom_range(k - 1);
        case (flaw)
            1: runs[j] = 16'd0;
            2: vals[j] = 8'($urandom_range(65, 255));
            3: runs[k - 1] = runs[k - 1] + 16'($urandom_range(1, 3));
            4: begin
                if (runs[k - 1] > 1) begin
                    runs[k - 1] = runs[k - 1] - 16'd1;
                end else if (k > 1) begin
                    k = k - 1;
                end
            end
            default: ;
        endcase
        send_header(asd_pkg::MODE_RUN, 14'(3 * k));
        for (int i = 0; i < k; i++) begin
            send_byte(runs[i][7:0]);
            send_byte(runs[i][15:8]);
            send_byte(vals[i]);
        end
    endtask

    task automatic send_random_frame();
        int unsigned sel;
        bit          corrupt;
        sel     = $urandom_range(99);
        corrupt = ($urandom_range(99) < 15);
        if (sel < 35) begin
            send_raw_frame(corrupt);
        end else if (sel < 55) begin
            send_single_frame(corrupt);
        end else if (sel < 85) begin
            send_run_frame(corrupt);
        end else if (sel < 92) begin
            send_header(asd_pkg::MODE_BAD, 14'($urandom_range(16383)));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_header_modes();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_span_count(16'd0);
        send_header(asd_pkg::MODE_RAW, 14'd0);
        send_header(asd_pkg::MODE_SINGLE, 14'(asd_pkg::SPAN_MAX));
        settle();
        write_span_count(16'hFFFF);
        send_header(asd_pkg::MODE_SINGLE, 14'd0);
        send_header(asd_pkg::MODE_RAW, 14'd0);
        send_header(asd_pkg::MODE_RUN, 14'd3);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'(asd_pkg::SPAN_MAX));
        send_header(asd_pkg::MODE_SINGLE, 14'h3FFF);
        send_header(asd_pkg::MODE_SINGLE, 14'd65);
        send_header(asd_pkg::MODE_BAD, 14'h3FFF);
        send_header(asd_pkg::MODE_RUN, 14'd0);
        send_header(asd_pkg::MODE_RUN, 14'd4);
        settle();
    endtask

    task automatic test_raw_checks();
        write_span_count(16'd2);
        send_header(asd_pkg::MODE_RAW, 14'd2);
        send_byte(8'h40);
        send_byte(8'h00);
        send_header(asd_pkg::MODE_RAW, 14'd2);
        send_byte(8'h01);
        send_byte(8'h80);
        // a bad span ends the frame at once; the rest of the payload reads as a header
        send_header(asd_pkg::MODE_RAW, 14'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        settle();
    endtask

    task automatic test_run_checks();
        write_span_count(16'd2);
        send_header(asd_pkg::MODE_RUN, 14'd3);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(asd_pkg::MODE_RUN, 14'd3);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h41);
        send_header(asd_pkg::MODE_RUN, 14'd3);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h01);
        send_header(asd_pkg::MODE_RUN, 14'd3);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h01);
        settle();
    endtask

    task automatic test_count_change();
        write_span_count(16'd2);
        send_header(asd_pkg::MODE_RAW, 14'd2);
        send_byte(8'h05);
        settle();
        write_span_count(16'd1);
        send_byte(8'h00);
        settle();
    endtask

    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_span_count(16'd16);
        holdoff_left = 300;
        repeat (4) send_raw_frame(1'b0);
        settle();
        write_span_count(16'd12);
        repeat (3) begin
            send_run_frame(1'b0);
            settle();
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
        int start;
        int last_cfg;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start              = bytes_sent;
        last_cfg           = bytes_sent;
        settle();
        write_span_count(pick_span_count());
        while (bytes_sent - start < count) begin
            if (bytes_sent - last_cfg >= 120) begin
                settle();
                write_span_count(pick_span_count());
                last_cfg = bytes_sent;
            end
            send_random_frame();
        end
        settle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 430);
        run_random_phase(81, 0, 430);
        run_random_phase(0, 81, 430);
        run_random_phase(32, 32, 430);
    endtask

    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            i_ready <= 1'b0;
            holdoff_left = holdoff_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_runs.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_repeat_res), 32'd0);
            end else begin
                oldest_run = expected_runs.pop_front();
                if (o_run_value !== oldest_run.run_value) begin
                    report_mismatch("run_value", 32'(o_run_value),
                                    32'(oldest_run.run_value));
                end
                if (o_repeat_res !== oldest_run.repeat_res) begin
                    report_mismatch("repeat_res", 32'(o_repeat_res),
                                    32'(oldest_run.repeat_res));
                end
                if (o_frame_end !== oldest_run.frame_end) begin
                    report_mismatch("frame_end", 32'(o_frame_end),
                                    32'(oldest_run.frame_end));
                end
                if (o_error_code !== 4'(oldest_run.error_code)) begin
                    report_mismatch("error_code", 32'(o_error_code),
                                    32'(oldest_run.error_code));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        dec_phase  = asd_pkg::PH_HDR_LO;
        hdr_lo     = '0;
        left_bytes = '0;
        bitbuf     = '0;
        nbits      = '0;
        spans_made = '0;
        entry_pos  = '0;
        run_len    = '0;
        cfg_spans  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_modes();
        test_raw_checks();
        test_run_checks();
        test_count_change();
        test_backpressure();
        test_random_traffic();
        settle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/asd_pkg.sv
sv/asd_front.sv
sv/asd_rq.sv
sv/asd_back.sv
sv/adaptive_span_stream_decoder_unit.sv
sv/asd_checker.sv
dv/tb_top.sv
